@@ rtl/vfc_pkg.sv @@
// ----------------------------------------------------------------------------
// vfc_pkg
// Shared types and constants for the voxel face cull unit: field widths,
// command codes, neighbor step codes and the structs between the modules.
// ----------------------------------------------------------------------------
package vfc_pkg;

   localparam int CHUNK_SIDE_DEF = 32;

   localparam int CMD_W      = 2;
   localparam int COORD_W    = 5;
   localparam int VALUE_W    = 32;
   localparam int FACE_W     = 6;
   localparam int REQ_DATA_W = 48;
   localparam int RSP_DATA_W = 40;

   // coordinate plus one guard bit, so a step below zero wraps far out of range
   localparam int NCOORD_W = COORD_W + 1;

   typedef logic [CMD_W-1:0] cmd_type;

   localparam cmd_type CMD_CLEAR = 2'd0;
   localparam cmd_type CMD_WRITE = 2'd1;
   localparam cmd_type CMD_QUERY = 2'd2;

   // read order of a query: the voxel itself, then one neighbor per face
   typedef logic [2:0] nbr_idx_type;

   localparam nbr_idx_type NBR_SELF  = 3'd0;
   localparam nbr_idx_type NBR_DOWN  = 3'd1;
   localparam nbr_idx_type NBR_UP    = 3'd2;
   localparam nbr_idx_type NBR_NORTH = 3'd3;
   localparam nbr_idx_type NBR_EAST  = 3'd4;
   localparam nbr_idx_type NBR_SOUTH = 3'd5;
   localparam nbr_idx_type NBR_WEST  = 3'd6;
   localparam nbr_idx_type NBR_LAST  = NBR_WEST;

   // tag that travels alongside one memory read
   typedef struct packed {
      logic        valid;
      nbr_idx_type idx;
      logic        oob;
   } rd_tag_type;

   // finished query from the face accumulator
   typedef struct packed {
      logic               done;
      logic [FACE_W-1:0]  faces;
      logic [VALUE_W-1:0] value;
   } acc_result_type;

endpackage

@@ rtl/voxel_face_cull_unit.sv @@
// ----------------------------------------------------------------------------
// voxel_face_cull_unit
// Voxel store with clear, write and exposed-face query. A small sequencer
// walks a query through seven reads of one memory port into a shared zero
// test, and sweeps the store on clear.
//
//   channel | dir | tuser      | tdata (low bit first)
//   req     | in  | [1:0] cmd  | coord_x, coord_y, coord_z, voxel_value, pad
//   rsp     | out | -          | exposed_faces, face_value, pad
//
// Write: accepted back to back. Query: the seven reads go one after another
// through the single read port of the store, and the next request is
// accepted only once the result beat is registered.
// Clear and reset: a sweep of one word per cycle over all 32768 words of the
// store at the default side; req_tready is low meanwhile.
// A finished query holds in the sequencer while the result register is full.
// ----------------------------------------------------------------------------
module voxel_face_cull_unit #(
   parameter int CHUNK_SIDE = vfc_pkg::CHUNK_SIDE_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   // coord_x [4:0], coord_y [9:5], coord_z [14:10], voxel_value [46:15]
   input  logic [vfc_pkg::REQ_DATA_W-1:0]    req_tdata,
   // cmd [1:0]
   input  logic [vfc_pkg::CMD_W-1:0]         req_tuser,
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   // exposed_faces [5:0], face_value [37:6]
   output logic [vfc_pkg::RSP_DATA_W-1:0]    rsp_tdata
);
   import vfc_pkg::*;

   // coordinates are 5 bits, so only the first 32 along each axis are reachable
   localparam int SIDE_EFF  = (CHUNK_SIDE < 32) ? CHUNK_SIDE : 32;
   localparam int CB        = $clog2(SIDE_EFF);
   localparam int ADDR_BITS = 3 * CB;
   localparam logic [NCOORD_W-1:0] SIDE_LIM = NCOORD_W'(SIDE_EFF);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_CLEAR,
      ST_QUERY,
      ST_HOLD
   } state_type;

   state_type                 state_ff, state_in;
   logic [ADDR_BITS-1:0]      clr_addr_ff, clr_addr_in;
   nbr_idx_type               issue_idx_ff, issue_idx_in;
   logic                      issue_on_ff, issue_on_in;
   logic [COORD_W-1:0]        qx_ff, qx_in, qy_ff, qy_in, qz_ff, qz_in;
   rd_tag_type                tag_ff, tag_in;
   logic                      rsp_valid_ff, rsp_valid_in;
   logic [RSP_DATA_W-1:0]     rsp_data_ff, rsp_data_in;

   logic [COORD_W-1:0]        req_x, req_y, req_z;
   logic [VALUE_W-1:0]        req_value;
   cmd_type                   req_cmd;
   logic                      req_fire, req_in_chunk, slot_free;

   logic [NCOORD_W-1:0]       nx, ny, nz;
   logic                      n_oob;

   logic                      wr_en, rd_en;
   logic [ADDR_BITS-1:0]      wr_addr, rd_addr;
   logic [VALUE_W-1:0]        wr_data, rd_data;
   acc_result_type            acc;

   assign req_x     = req_tdata[4:0];
   assign req_y     = req_tdata[9:5];
   assign req_z     = req_tdata[14:10];
   assign req_value = req_tdata[46:15];
   assign req_cmd   = req_tuser;

   assign req_tready   = (state_ff == ST_IDLE);
   assign req_fire     = req_tvalid && req_tready;
   assign req_in_chunk = ({1'b0, req_x} < SIDE_LIM) && ({1'b0, req_y} < SIDE_LIM)
                         && ({1'b0, req_z} < SIDE_LIM);
   assign slot_free    = !rsp_valid_ff || rsp_tready;

   // neighbor of the current read step; a step below zero wraps to all ones
   always_comb begin
      nx = {1'b0, qx_ff};
      ny = {1'b0, qy_ff};
      nz = {1'b0, qz_ff};
      case (issue_idx_ff)
         NBR_SELF:  nx = {1'b0, qx_ff};
         NBR_DOWN:  ny = {1'b0, qy_ff} - NCOORD_W'(1);
         NBR_UP:    ny = {1'b0, qy_ff} + NCOORD_W'(1);
         NBR_NORTH: nz = {1'b0, qz_ff} + NCOORD_W'(1);
         NBR_EAST:  nx = {1'b0, qx_ff} - NCOORD_W'(1);
         NBR_SOUTH: nz = {1'b0, qz_ff} - NCOORD_W'(1);
         NBR_WEST:  nx = {1'b0, qx_ff} + NCOORD_W'(1);
         default:   nx = {1'b0, qx_ff};
      endcase
      n_oob = (nx >= SIDE_LIM) || (ny >= SIDE_LIM) || (nz >= SIDE_LIM);
   end

   assign rd_en   = (state_ff == ST_QUERY) && issue_on_ff;
   assign rd_addr = {nz[CB-1:0], ny[CB-1:0], nx[CB-1:0]};

   always_comb begin
      wr_en   = 1'b0;
      wr_addr = clr_addr_ff;
      wr_data = '0;
      if (state_ff == ST_CLEAR) begin
         wr_en = 1'b1;
      end else if (req_fire && (req_cmd == CMD_WRITE) && req_in_chunk) begin
         wr_en   = 1'b1;
         wr_addr = {req_z[CB-1:0], req_y[CB-1:0], req_x[CB-1:0]};
         wr_data = req_value;
      end
   end

   always_comb begin
      state_in     = state_ff;
      clr_addr_in  = clr_addr_ff;
      issue_idx_in = issue_idx_ff;
      issue_on_in  = issue_on_ff;
      qx_in        = qx_ff;
      qy_in        = qy_ff;
      qz_in        = qz_ff;
      tag_in       = '0;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;

      case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               case (req_cmd)
                  CMD_CLEAR: begin
                     state_in    = ST_CLEAR;
                     clr_addr_in = '0;
                  end
                  CMD_QUERY: begin
                     state_in     = ST_QUERY;
                     qx_in        = req_x;
                     qy_in        = req_y;
                     qz_in        = req_z;
                     issue_idx_in = NBR_SELF;
                     issue_on_in  = 1'b1;
                  end
                  default: begin
                     state_in = ST_IDLE;
                  end
               endcase
            end
         end
         ST_CLEAR: begin
            clr_addr_in = clr_addr_ff + ADDR_BITS'(1);
            if (&clr_addr_ff) begin
               state_in = ST_IDLE;
            end
         end
         ST_QUERY: begin
            if (issue_on_ff) begin
               tag_in.valid = 1'b1;
               tag_in.idx   = issue_idx_ff;
               tag_in.oob   = n_oob;
               if (issue_idx_ff == NBR_LAST) begin
                  issue_on_in = 1'b0;
               end else begin
                  issue_idx_in = issue_idx_ff + 3'd1;
               end
            end
            if (acc.done) begin
               if (slot_free) begin
                  rsp_valid_in = 1'b1;
                  rsp_data_in  = {2'b00, acc.value, acc.faces};
                  state_in     = ST_IDLE;
               end else begin
                  state_in = ST_HOLD;
               end
            end
         end
         ST_HOLD: begin
            // accumulator keeps its result until the next query starts
            if (slot_free) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = {2'b00, acc.value, acc.faces};
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_addr_ff  <= '0;
         issue_idx_ff <= NBR_SELF;
         issue_on_ff  <= 1'b0;
         tag_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_addr_ff  <= clr_addr_in;
         issue_idx_ff <= issue_idx_in;
         issue_on_ff  <= issue_on_in;
         tag_ff       <= tag_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      qx_ff       <= qx_in;
      qy_ff       <= qy_in;
      qz_ff       <= qz_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   vfc_voxel_ram #(
      .ADDR_BITS (ADDR_BITS),
      .DATA_W    (VALUE_W)
   ) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   vfc_face_acc u_acc (
      .clock   (clock),
      .reset   (reset),
      .tag     (tag_ff),
      .rd_data (rd_data),
      .result  (acc)
   );

endmodule

@@ rtl/vfc_voxel_ram.sv @@
// ----------------------------------------------------------------------------
// vfc_voxel_ram
// Voxel store: one write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module vfc_voxel_ram #(
   parameter int ADDR_BITS = 15,
   parameter int DATA_W    = vfc_pkg::VALUE_W
) (
   input  logic                 clock,
   input  logic                 wr_en,
   input  logic [ADDR_BITS-1:0] wr_addr,
   input  logic [DATA_W-1:0]    wr_data,
   input  logic                 rd_en,
   input  logic [ADDR_BITS-1:0] rd_addr,
   output logic [DATA_W-1:0]    rd_data
);
   import vfc_pkg::*;

   localparam int DEPTH = 1 << ADDR_BITS;

   logic [DATA_W-1:0] mem [DEPTH];
   logic [DATA_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ rtl/vfc_face_acc.sv @@
// ----------------------------------------------------------------------------
// vfc_face_acc
// Face accumulator: one zero test per cycle on the word coming back from the
// store. The first read of a query keeps the voxel word, each later read sets
// the face bit of an empty neighbor while the voxel is occupied.
// ----------------------------------------------------------------------------
module vfc_face_acc (
   input  logic                     clock,
   input  logic                     reset,
   input  vfc_pkg::rd_tag_type      tag,
   input  logic [vfc_pkg::VALUE_W-1:0] rd_data,
   output vfc_pkg::acc_result_type  result
);
   import vfc_pkg::*;

   logic [VALUE_W-1:0] self_ff, self_in;
   logic [FACE_W-1:0]  faces_ff, faces_in;
   logic               done_ff, done_in;
   logic [VALUE_W-1:0] word;
   logic               empty;
   nbr_idx_type        face_sel;

   always_comb begin
      word     = tag.oob ? '0 : rd_data;
      empty    = (word == '0);
      face_sel = nbr_idx_type'(tag.idx - 3'd1);
      self_in  = self_ff;
      faces_in = faces_ff;
      done_in  = 1'b0;
      if (tag.valid) begin
         if (tag.idx == NBR_SELF) begin
            self_in  = word;
            faces_in = '0;
         end else if (empty && (self_ff != '0)) begin
            faces_in[face_sel] = 1'b1;
         end
         done_in = (tag.idx == NBR_LAST);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         done_ff <= 1'b0;
      end else begin
         done_ff <= done_in;
      end
      self_ff  <= self_in;
      faces_ff <= faces_in;
   end

   assign result.done  = done_ff;
   assign result.faces = faces_ff;
   assign result.value = self_ff;

endmodule

@@ dv/face_cull_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// face_cull_checker
// Watches the request and result streams of the voxel face cull unit. It
// keeps its own copy of the voxel store, and works out the face mask and
// value of every accepted query. Each result beat is compared field by field
// with the oldest open query.
// ----------------------------------------------------------------------------
module face_cull_checker #(
   parameter int CHUNK_SIDE = vfc_pkg::CHUNK_SIDE_DEF
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_tvalid,
   input  logic                           req_tready,
   // coord_x [4:0], coord_y [9:5], coord_z [14:10], voxel_value [46:15]
   input  logic [vfc_pkg::REQ_DATA_W-1:0] req_tdata,
   // cmd [1:0]
   input  logic [vfc_pkg::CMD_W-1:0]      req_tuser,
   input  logic                           rsp_tvalid,
   input  logic                           rsp_tready,
   // exposed_faces [5:0], face_value [37:6]
   input  logic [vfc_pkg::RSP_DATA_W-1:0] rsp_tdata,
   output int                             mismatch_count,
   output int                             open_count
);

   import vfc_pkg::*;

   localparam int STORE_WORDS = CHUNK_SIDE * CHUNK_SIDE * CHUNK_SIDE;

   // bit positions of the face mask
   localparam int FACE_DOWN  = 0;
   localparam int FACE_UP    = 1;
   localparam int FACE_NORTH = 2;
   localparam int FACE_EAST  = 3;
   localparam int FACE_SOUTH = 4;
   localparam int FACE_WEST  = 5;

   typedef struct packed {
      logic [FACE_W-1:0]  faces;
      logic [VALUE_W-1:0] value;
   } face_result_type;

   logic [VALUE_W-1:0] voxel_words [STORE_WORDS];
   face_result_type    open_queries [$];
   int                 fail_total = 0;
   int                 open_total = 0;

   assign mismatch_count = fail_total;
   assign open_count     = open_total;

   function automatic logic in_chunk(int x, int y, int z);
      return x >= 0 && x < CHUNK_SIDE && y >= 0 && y < CHUNK_SIDE &&
             z >= 0 && z < CHUNK_SIDE;
   endfunction

   function automatic int word_addr(int x, int y, int z);
      return x + y * CHUNK_SIDE * CHUNK_SIDE + z * CHUNK_SIDE;
   endfunction

   // anything outside the chunk reads as empty
   function automatic logic [VALUE_W-1:0] voxel_at(int x, int y, int z);
      if (!in_chunk(x, y, z))
         return '0;
      return voxel_words[word_addr(x, y, z)];
   endfunction

   function automatic face_result_type predict_faces(int x, int y, int z);
      face_result_type r;
      r.value = voxel_at(x, y, z);
      r.faces = '0;
      if (r.value != '0) begin
         r.faces[FACE_DOWN]  = voxel_at(x, y - 1, z) == '0;
         r.faces[FACE_UP]    = voxel_at(x, y + 1, z) == '0;
         r.faces[FACE_NORTH] = voxel_at(x, y, z + 1) == '0;
         r.faces[FACE_EAST]  = voxel_at(x - 1, y, z) == '0;
         r.faces[FACE_SOUTH] = voxel_at(x, y, z - 1) == '0;
         r.faces[FACE_WEST]  = voxel_at(x + 1, y, z) == '0;
      end
      return r;
   endfunction

   task automatic clear_store();
      for (int i = 0; i < STORE_WORDS; i++)
         voxel_words[i] = '0;
   endtask

   task automatic note_mismatch(string field, logic [VALUE_W-1:0] want,
                                logic [VALUE_W-1:0] got);
      if (fail_total < 10)
         $display("%0t ns: %s mismatch, expected %h, actual %h", $time, field, want, got);
      fail_total++;
   endtask

   always @(posedge clock) begin : watch
      face_result_type seen;
      face_result_type want;
      int x, y, z;
      if (reset) begin
         clear_store();
         open_queries.delete();
      end else begin
         if (req_tvalid && req_tready) begin
            x = int'(req_tdata[4:0]);
            y = int'(req_tdata[9:5]);
            z = int'(req_tdata[14:10]);
            case (req_tuser)
               CMD_CLEAR: clear_store();
               CMD_WRITE: begin
                  if (in_chunk(x, y, z))
                     voxel_words[word_addr(x, y, z)] = req_tdata[46:15];
               end
               CMD_QUERY: open_queries = {open_queries, predict_faces(x, y, z)};
               default: ;
            endcase
         end
         if (rsp_tvalid && rsp_tready) begin
            seen.faces = rsp_tdata[5:0];
            seen.value = rsp_tdata[37:6];
            if (open_queries.size() == 0) begin
               note_mismatch("unexpected beat", '0, seen.value);
            end else begin
               want = open_queries.pop_front();
               if (seen.faces != want.faces)
                  note_mismatch("exposed_faces", VALUE_W'(want.faces),
                                VALUE_W'(seen.faces));
               if (seen.value != want.value)
                  note_mismatch("face_value", want.value, seen.value);
            end
         end
      end
      open_total <= open_queries.size();
   end

endmodule

@@ dv/tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Drives the voxel face cull unit with clears, writes, queries and the unused
// command: a short directed set over corners and neighbors, then random
// traffic packed into small boxes so that neighbors meet, with random gaps
// on both streams. The checker beside the unit predicts and compares.
// ----------------------------------------------------------------------------
module tb;

   import vfc_pkg::*;

   // code with no function in the unit, must be dropped silently
   localparam cmd_type CMD_UNUSED = 2'd3;
   localparam int      CYCLE_LIMIT = 1_500_000;
   localparam int      BOX_ITEMS = 40;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata = '0;
   logic [CMD_W-1:0]      req_tuser = CMD_CLEAR;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic                  idle_on = 1'b1;
   int                    mismatch_count;
   int                    open_count;
   int                    cycle_count;

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   voxel_face_cull_unit DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   face_cull_checker u_checker (
      .clock          (clock),
      .reset          (reset),
      .req_tvalid     (req_tvalid),
      .req_tready     (req_tready),
      .req_tdata      (req_tdata),
      .req_tuser      (req_tuser),
      .rsp_tvalid     (rsp_tvalid),
      .rsp_tready     (rsp_tready),
      .rsp_tdata      (rsp_tdata),
      .mismatch_count (mismatch_count),
      .open_count     (open_count)
   );

   always @(posedge clock) begin
      rsp_tready <= !idle_on || $urandom_range(99) >= 24;
   end

   task automatic send_cmd(cmd_type cmd, logic [COORD_W-1:0] x, logic [COORD_W-1:0] y,
                           logic [COORD_W-1:0] z, logic [VALUE_W-1:0] value);
      while (idle_on && $urandom_range(99) < 24) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= cmd;
      req_tdata  <= {1'b0, value, z, y, x};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
   endtask

   // mostly occupied words, with a fair share of empty ones
   function automatic logic [VALUE_W-1:0] voxel_word();
      case ($urandom_range(9))
         0, 1, 2: return '0;
         3:       return '1;
         4:       return 32'd1;
         default: return $urandom;
      endcase
   endfunction

   // pull boxes toward the chunk borders now and then
   function automatic int box_origin(int span);
      case ($urandom_range(3))
         0:       return 0;
         1:       return 32 - span;
         default: return $urandom_range(32 - span);
      endcase
   endfunction

   task automatic run_phase(int count);
      int bx, by, bz, span, pick;
      logic [COORD_W-1:0] x, y, z;
      repeat (count / BOX_ITEMS) begin
         span = $urandom_range(4, 2);
         bx = box_origin(span);
         by = box_origin(span);
         bz = box_origin(span);
         repeat (BOX_ITEMS) begin
            pick = $urandom_range(99);
            x = COORD_W'(bx + $urandom_range(span - 1));
            y = COORD_W'(by + $urandom_range(span - 1));
            z = COORD_W'(bz + $urandom_range(span - 1));
            if (pick < 45)
               send_cmd(CMD_WRITE, x, y, z, voxel_word());
            else if (pick < 90)
               send_cmd(CMD_QUERY, x, y, z, $urandom);
            else if (pick < 95)
               send_cmd(CMD_QUERY, COORD_W'($urandom_range(31)),
                        COORD_W'($urandom_range(31)), COORD_W'($urandom_range(31)),
                        $urandom);
            else if (pick < 98)
               send_cmd(CMD_WRITE, COORD_W'($urandom_range(31)),
                        COORD_W'($urandom_range(31)), COORD_W'($urandom_range(31)),
                        voxel_word());
            else
               send_cmd(CMD_UNUSED, COORD_W'($urandom_range(31)),
                        COORD_W'($urandom_range(31)), COORD_W'($urandom_range(31)),
                        $urandom);
         end
      end
   endtask

   initial begin
      cycle_count = 0;
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

   initial begin
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // empty store, lone corner voxels, then hidden faces between neighbors
      send_cmd(CMD_QUERY, 5'd0, 5'd0, 5'd0, '0);
      send_cmd(CMD_WRITE, 5'd0, 5'd0, 5'd0, '1);
      send_cmd(CMD_QUERY, 5'd0, 5'd0, 5'd0, '0);
      send_cmd(CMD_WRITE, 5'd31, 5'd31, 5'd31, 32'd1);
      send_cmd(CMD_QUERY, 5'd31, 5'd31, 5'd31, '1);
      send_cmd(CMD_WRITE, 5'd1, 5'd0, 5'd0, 32'h8000_0000);
      send_cmd(CMD_WRITE, 5'd0, 5'd1, 5'd0, 32'h0000_ffff);
      send_cmd(CMD_WRITE, 5'd0, 5'd0, 5'd1, 32'hffff_0000);
      send_cmd(CMD_QUERY, 5'd0, 5'd0, 5'd0, '0);
      send_cmd(CMD_QUERY, 5'd1, 5'd0, 5'd0, '0);
      send_cmd(CMD_UNUSED, 5'd31, 5'd31, 5'd31, '1);
      send_cmd(CMD_WRITE, 5'd0, 5'd0, 5'd0, '0);
      send_cmd(CMD_QUERY, 5'd0, 5'd0, 5'd0, '0);
      send_cmd(CMD_QUERY, 5'd0, 5'd1, 5'd0, '0);
      send_cmd(CMD_CLEAR, 5'd0, 5'd0, 5'd0, '0);
      send_cmd(CMD_QUERY, 5'd31, 5'd31, 5'd31, '0);
      send_cmd(CMD_QUERY, 5'd1, 5'd0, 5'd0, '0);

      run_phase(200);
      send_cmd(CMD_CLEAR, 5'd0, 5'd0, 5'd0, '0);
      // long stretch with both streams running flat out
      idle_on <= 1'b0;
      run_phase(200);
      idle_on <= 1'b1;
      send_cmd(CMD_CLEAR, 5'd0, 5'd0, 5'd0, '0);
      run_phase(200);
      run_phase(160);
      req_tvalid <= 1'b0;

      // let the checker see the last beat before looking at its open count
      @(posedge clock);
      while (open_count != 0) @(posedge clock);
      repeat (16) @(posedge clock);

      if (mismatch_count == 0)
         $display("SCOREBOARD CLEAN");
      else
         $display("SCOREBOARD MISMATCH");
      $finish;
   end

endmodule
